// File: rtl/core/blo_pkg.sv
// Package for the bounded ordered list: request kinds, the command broadcast
// to every storage cell and the link record passed between neighbor cells.
// No dependencies.
package blo_pkg;

   localparam int ValueW  = 32;
   localparam int KindW   = 2;
   localparam int LengthW = 5;

   localparam logic [KindW-1:0] KIND_FRONT  = 2'd0;
   localparam logic [KindW-1:0] KIND_BACK   = 2'd1;
   localparam logic [KindW-1:0] KIND_DELETE = 2'd2;
   localparam logic [KindW-1:0] KIND_SEARCH = 2'd3;

   // One stored slot as seen by a neighbor.
   typedef struct packed {
      logic              valid;
      logic [ValueW-1:0] data;
   } link_type;

   // Broadcast to all cells for the transaction being applied.
   typedef struct packed {
      logic              go;
      logic [KindW-1:0]  kind;
      logic [ValueW-1:0] value;
      logic              full;
   } cmd_type;

endpackage

// File: rtl/core/blo_req_if.sv
// Request channel of the bounded ordered list: valid/ready plus kind and value.
// Depends on blo_pkg for field widths.
interface blo_req_if import blo_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KindW-1:0]         kind;
   logic signed [ValueW-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

// File: rtl/core/blo_rsp_if.sv
// Response channel of the bounded ordered list: valid/ready plus the four
// result fields. Depends on blo_pkg for field widths.
interface blo_rsp_if import blo_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               found;
   logic               removed;
   logic               accepted;
   logic [LengthW-1:0] length;

   modport source (output valid, output found, output removed, output accepted,
                   output length, input ready);
   modport sink   (input valid, input found, input removed, input accepted,
                   input length, output ready);
endinterface

// File: rtl/core/blo_cell.sv
// One storage cell of the ordered list: holds a value and its valid bit,
// compares against the request value and shifts from either neighbor.
// Depends on blo_pkg.
module blo_cell import blo_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  link_type left,
   input  link_type right,
   input  logic     seen_in,
   output link_type self_out,
   output logic     seen_out
);

   logic              valid_ff, valid_in;
   logic [ValueW-1:0] data_ff, data_in;
   logic              match;

   assign match    = valid_ff && (data_ff == cmd.value);
   // Set at and behind the front-most match.
   assign seen_out = seen_in | match;
   assign self_out = '{valid: valid_ff, data: data_ff};

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (cmd.go) begin
         unique case (cmd.kind)
            KIND_FRONT: begin
               if (!cmd.full) begin
                  valid_in = left.valid;
                  data_in  = left.data;
               end
            end
            KIND_BACK: begin
               // Only the first empty cell takes the value.
               if (!cmd.full && !valid_ff && left.valid) begin
                  valid_in = 1'b1;
                  data_in  = cmd.value;
               end
            end
            KIND_DELETE: begin
               // Close the gap left by the first match.
               if (seen_out) begin
                  valid_in = right.valid;
                  data_in  = right.data;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// File: rtl/core/bounded_ordered_list.sv
// Bounded ordered list of signed 32-bit values built as a row of storage
// cells. Depends on blo_pkg, blo_req_if, blo_rsp_if and blo_cell.
//
// Usage:
//   req channel: kind (insert front, insert back, delete first match, search)
//   and value. rsp channel: found, removed, accepted and the list length after
//   the request. Every request yields exactly one response.
//   All cells compare the value and shift toward front or back in the same
//   cycle, so a request is applied in the cycle it is accepted and its
//   response is shown in the next cycle from the output register.
//   Throughput: one request per cycle while the response side keeps up; the
//   single output register is the only buffering, so req.ready drops while a
//   response waits and rsp.ready is low.
//   Reset (synchronous, active high) empties the list and drops any pending
//   response; stored values are not cleared, only their valid bits.
//   An insert into a full list is refused with accepted = 0. With CAPACITY
//   above 31 the length field carries the low 5 bits of the count.
module bounded_ordered_list import blo_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic         clock,
   input  logic         reset,
   blo_req_if.sink      req,
   blo_rsp_if.source    rsp
);

   localparam int CountW = $clog2(CAPACITY + 1);

   logic              req_fire;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              found_ff, removed_ff, accepted_ff;
   logic [LengthW-1:0] length_ff;
   logic [CountW-1:0] count_ff, count_in;
   logic              full;
   logic              accept_in, remove_in, found_in;
   logic [CountW+LengthW-1:0] length_ext;
   cmd_type           cmd;
   link_type          cell_q [CAPACITY];
   link_type          left_q [CAPACITY];
   link_type          right_q [CAPACITY];
   logic [CAPACITY:0] seen;
   logic [CAPACITY-1:0] valid_vec;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;
   assign full      = (count_ff == CountW'(CAPACITY));

   assign cmd = '{go: req_fire, kind: req.kind, value: req.value, full: full};

   assign seen[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_q[i] = '{valid: 1'b1, data: req.value};
      end else begin : g_mid
         assign left_q[i] = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_q[i] = '{valid: 1'b0, data: '0};
      end else begin : g_inner
         assign right_q[i] = cell_q[i+1];
      end
      assign valid_vec[i] = cell_q[i].valid;

      blo_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .left     (left_q[i]),
         .right    (right_q[i]),
         .seen_in  (seen[i]),
         .self_out (cell_q[i]),
         .seen_out (seen[i+1])
      );
   end

   assign found_in  = seen[CAPACITY];
   assign accept_in = (req.kind == KIND_FRONT || req.kind == KIND_BACK) && !full;
   assign remove_in = (req.kind == KIND_DELETE) && found_in;

   always_comb begin
      count_in = count_ff;
      if (req_fire) begin
         if (accept_in) begin
            count_in = count_ff + CountW'(1);
         end else if (remove_in) begin
            count_in = count_ff - CountW'(1);
         end
      end
   end

   assign length_ext   = {{LengthW{1'b0}}, count_in};
   assign rsp_valid_in = req_fire ? 1'b1 : (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response until it is taken.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         found_ff    <= found_in;
         removed_ff  <= remove_in;
         accepted_ff <= accept_in;
         length_ff   <= length_ext[LengthW-1:0];
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.found    = found_ff;
   assign rsp.removed  = removed_ff;
   assign rsp.accepted = accepted_ff;
   assign rsp.length   = length_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(CAPACITY))
      else $error("entry count above capacity");

   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("cell valid bits disagree with entry count");

   a_front_packed: assert property (@(posedge clock) disable iff (reset)
      $onehot0(valid_vec ^ (valid_vec >> 1)) && (valid_vec[0] || valid_vec == '0))
      else $error("valid cells not packed at the front");

   a_rsp_after_fire: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted transaction produced no response");
`endif

endmodule

// File: verif/tb.sv
// Self-checking testbench for bounded_ordered_list: a shadow list predicts
// every response and a checker compares it field by field.
// Depends on blo_pkg, blo_req_if, blo_rsp_if and the bounded_ordered_list RTL.
module tb;
   import blo_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP        = 16;
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic               found;
      logic               removed;
      logic               accepted;
      logic [LengthW-1:0] length;
   } list_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   blo_req_if req_bus ();
   blo_rsp_if rsp_bus ();

   bounded_ordered_list #(.CAPACITY(CAP)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   logic [ValueW-1:0] shadow_list[$];
   list_outcome_type  pending_outcomes[$];

   bit idle_on      = 1'b0;
   int errors       = 0;
   int sent         = 0;
   int checked      = 0;
   int refused      = 0;
   int removals     = 0;
   int misses       = 0;
   int longest      = 0;
   int idle_cycles  = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // Apply one request to the shadow list and return what the block must answer.
   function automatic list_outcome_type apply_request(input logic [KindW-1:0] kind,
                                                      input logic [ValueW-1:0] value);
      list_outcome_type o;
      int hit;
      o   = '0;
      hit = -1;
      for (int i = 0; i < shadow_list.size(); i++) begin
         if (hit < 0 && shadow_list[i] == value) hit = i;
      end
      o.found = (hit >= 0);
      case (kind) inside
         KIND_FRONT, KIND_BACK: begin
            if (shadow_list.size() < CAP) begin
               if (kind == KIND_FRONT) shadow_list.push_front(value);
               else shadow_list.push_back(value);
               o.accepted = 1'b1;
            end else begin
               refused++;
            end
         end
         KIND_DELETE: begin
            if (hit >= 0) begin
               shadow_list.delete(hit);
               o.removed = 1'b1;
               removals++;
            end else begin
               misses++;
            end
         end
         default: begin
            if (hit < 0) misses++;
         end
      endcase
      o.length = LengthW'(shadow_list.size());
      if (shadow_list.size() > longest) longest = shadow_list.size();
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int exp_v, input int got_v);
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
      errors++;
   endtask

   task automatic send_request(input logic [KindW-1:0] kind, input logic [ValueW-1:0] value);
      int gap;
      gap = (idle_on && $urandom_range(0, 1)) ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      pending_outcomes.push_back(apply_request(kind, value));
      sent++;
   endtask

   // Hold off the request side until every response is back.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [ValueW-1:0] pick_value();
      if (shadow_list.size() != 0 && $urandom_range(0, 1))
         return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 7);
      return $urandom;
   endfunction

   task automatic test_empty_list();
      send_request(KIND_SEARCH, 32'h0000_0000);
      send_request(KIND_DELETE, 32'h0000_0000);
      send_request(KIND_DELETE, 32'h8000_0000);
   endtask

   task automatic test_extremes();
      send_request(KIND_FRONT, 32'h8000_0000);
      send_request(KIND_BACK, 32'h7FFF_FFFF);
      send_request(KIND_FRONT, 32'h0000_0000);
      send_request(KIND_BACK, 32'hFFFF_FFFF);
      send_request(KIND_SEARCH, 32'h7FFF_FFFF);
      send_request(KIND_DELETE, 32'h8000_0000);
   endtask

   task automatic test_duplicates();
      send_request(KIND_BACK, 32'd5);
      send_request(KIND_FRONT, 32'd5);
      send_request(KIND_DELETE, 32'd5);
      send_request(KIND_SEARCH, 32'd5);
      send_request(KIND_DELETE, 32'd6);
   endtask

   task automatic test_full_list();
      while (shadow_list.size() < CAP)
         send_request($urandom_range(0, 1) ? KIND_FRONT : KIND_BACK, $urandom);
      send_request(KIND_FRONT, 32'd9);
      send_request(KIND_BACK, 32'd9);
      send_request(KIND_SEARCH, shadow_list[CAP-1]);
      send_request(KIND_DELETE, shadow_list[CAP-1]);
   endtask

   // Alternate fill and drain bias so the length sweeps from empty to full.
   task automatic test_random_traffic();
      int ins_pct;
      int r;
      for (int phase = 0; phase < 7; phase++) begin
         idle_on = (phase != 0);
         ins_pct = (phase % 3 == 0) ? 50 : ((phase % 3 == 1) ? 72 : 28);
         for (int n = 0; n < 250; n++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct)
               send_request($urandom_range(0, 1) ? KIND_FRONT : KIND_BACK, pick_value());
            else if (r < ins_pct + (100 - ins_pct) * 2 / 3)
               send_request(KIND_DELETE, pick_value());
            else
               send_request(KIND_SEARCH, pick_value());
         end
         wait_drained();
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.kind  = KIND_SEARCH;
      req_bus.value = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      idle_on = 1'b1;
      test_extremes();
      test_duplicates();
      test_full_list();
      wait_drained();
      test_random_traffic();

      wait_drained();
      repeat (4) @(posedge clock);
      $display("sent %0d requests, checked %0d responses, longest list %0d of %0d",
               sent, checked, longest, CAP);
      $display("inserts refused when full %0d, deletes that removed %0d, misses %0d",
               refused, removals, misses);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Response-side backpressure: with idle_on, stretches of stalls and stretches held open; else always ready.
   initial begin
      int n;
      rsp_bus.ready = 1'b0;
      forever begin
         if (!idle_on) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            n = pick_gap();
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
            n = $urandom_range(1, 12);
            @(negedge clock);
            rsp_bus.ready <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      list_outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t response transaction with nothing outstanding", $realtime);
            errors++;
         end else begin
            want = pending_outcomes.pop_front();
            checked++;
            if (rsp_bus.found !== want.found)
               report_mismatch("found", int'(want.found), int'(rsp_bus.found));
            if (rsp_bus.removed !== want.removed)
               report_mismatch("removed", int'(want.removed), int'(rsp_bus.removed));
            if (rsp_bus.accepted !== want.accepted)
               report_mismatch("accepted", int'(want.accepted), int'(rsp_bus.accepted));
            if (rsp_bus.length !== want.length)
               report_mismatch("length", int'(want.length), int'(rsp_bus.length));
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t watchdog expired, %0d responses outstanding",
                  $realtime, pending_outcomes.size());
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
